### rtl/bale_pkg.sv
// ----------------------------------------------------------------------------
// bale_pkg
// Shared types and codes for the bounded array list engine.
// ----------------------------------------------------------------------------
package bale_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_READ   = 3'd2;
    localparam logic [2:0] CMD_APPEND = 3'd3;
    localparam logic [2:0] CMD_DROP   = 3'd4;
    localparam logic [2:0] CMD_CLEAR  = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [3:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [4:0]         length;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_APPEND,
        OP_DROP,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        logic       load;
        t_dp_op     op;
        logic [1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [CNT_W-1:0] count;
    } t_dp_stat;

endpackage

### rtl/bounded_array_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine
// Ordered list of up to DEPTH signed words with positional insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   Command items enter on the in channel (valid/ready): cmd, position, value.
//   Each item gives exactly one result item on the out channel: read_value,
//   length after the command, and status (ok, bad position, full, empty).
//   A result appears the cycle after its item is taken.
//   Throughput is one item per cycle while the receiver takes results;
//   insert and delete shift the whole register row at once through per-cell
//   shift enables, and the result register frees as it is taken, so a new
//   item enters in the same cycle the previous result leaves.
//   When the receiver stalls the result is held and in_ready drops until the
//   result is taken.
//   Reset empties the list (length zero) and clears the output slot; stored
//   words are not cleared, and no position at or above the length is read.
// ----------------------------------------------------------------------------
module bounded_array_list_engine (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  bale_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bale_pkg::t_out_item  o_out_item
);
    import bale_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bale_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_in_item.cmd),
        .i_position  (i_in_item.position),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bale_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_position (i_in_item.position),
        .i_value    (i_in_item.value),
        .o_stat     (dp_stat),
        .o_item     (o_out_item)
    );

endmodule

### rtl/bale_ctrl.sv
// ----------------------------------------------------------------------------
// bale_ctrl
// Handshake control, command decode and checks, output slot tracking.
// ----------------------------------------------------------------------------
module bale_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_cmd,
    input  logic [3:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  bale_pkg::t_dp_stat i_stat,
    output bale_pkg::t_dp_cmd  o_cmd
);
    import bale_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_FULL
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             accept;
    logic [CNT_W-1:0] pos_ext;
    t_dp_op           op;
    logic [1:0]       status;

    assign o_in_ready  = (r_state == S_EMPTY) || i_out_ready;
    assign o_out_valid = (r_state == S_FULL);
    assign accept      = i_in_valid && o_in_ready;
    assign pos_ext     = CNT_W'(i_position);

    always_comb begin
        op     = OP_NONE;
        status = ST_OK;
        unique case (i_cmd)
            CMD_INSERT: begin
                if (i_stat.full) begin
                    status = ST_FULL;
                end else if (pos_ext > i_stat.count) begin
                    status = ST_BADPOS;
                end else begin
                    op = OP_INSERT;
                end
            end
            CMD_DELETE: begin
                if (i_stat.empty) begin
                    status = ST_EMPTY;
                end else if (pos_ext >= i_stat.count) begin
                    status = ST_BADPOS;
                end else begin
                    op = OP_DELETE;
                end
            end
            CMD_READ: begin
                if (pos_ext >= i_stat.count) begin
                    status = ST_BADPOS;
                end else begin
                    op = OP_READ;
                end
            end
            CMD_APPEND: begin
                if (i_stat.full) begin
                    status = ST_FULL;
                end else begin
                    op = OP_APPEND;
                end
            end
            CMD_DROP: begin
                if (i_stat.empty) begin
                    status = ST_EMPTY;
                end else begin
                    op = OP_DROP;
                end
            end
            CMD_CLEAR: begin
                op = OP_CLEAR;
            end
            default: begin
                op = OP_NONE;
            end
        endcase
    end

    assign o_cmd.load   = accept;
    assign o_cmd.op     = op;
    assign o_cmd.status = status;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (accept) begin
                    n_state = S_FULL;
                end
            end
            S_FULL: begin
                if (!accept && i_out_ready) begin
                    n_state = S_EMPTY;
                end
            end
            default: begin
                n_state = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    ctrl_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_cmd.load)
        else $error("item loaded while result stalled");

    ctrl_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("loaded item gave no result");

    ctrl_full_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_stat.full && (o_cmd.op == OP_INSERT || o_cmd.op == OP_APPEND)) |-> 0)
        else $error("growth issued on full list");

endmodule

### rtl/bale_dpath.sv
// ----------------------------------------------------------------------------
// bale_dpath
// Register row with per-cell shift enables, length counter, result register.
// ----------------------------------------------------------------------------
module bale_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bale_pkg::t_dp_cmd  i_cmd,
    input  logic [3:0]         i_position,
    input  logic signed [31:0] i_value,
    output bale_pkg::t_dp_stat o_stat,
    output bale_pkg::t_out_item o_item
);
    import bale_pkg::*;

    logic signed [31:0] r_entries [DEPTH];
    logic signed [31:0] n_entries [DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic signed [31:0] r_read_value;
    logic [1:0]         r_status;
    logic [CNT_W-1:0]   pos_ext;

    assign pos_ext = CNT_W'(i_position);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        always_comb begin
            n_entries[g] = r_entries[g];
            case (i_cmd.op)
                OP_INSERT: begin
                    if (CNT_W'(g) == pos_ext) begin
                        n_entries[g] = i_value;
                    end else if (CNT_W'(g) > pos_ext) begin
                        if (g > 0) begin
                            n_entries[g] = r_entries[(g > 0) ? g - 1 : 0];
                        end
                    end
                end
                OP_DELETE: begin
                    if (CNT_W'(g) >= pos_ext && g < DEPTH - 1) begin
                        n_entries[g] = r_entries[(g < DEPTH - 1) ? g + 1 : g];
                    end
                end
                OP_APPEND: begin
                    if (CNT_W'(g) == r_count) begin
                        n_entries[g] = i_value;
                    end
                end
                default: begin
                    n_entries[g] = r_entries[g];
                end
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_entries[g] <= n_entries[g];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        case (i_cmd.op)
            OP_INSERT, OP_APPEND: n_count = r_count + CNT_W'(1);
            OP_DELETE, OP_DROP:   n_count = r_count - CNT_W'(1);
            OP_CLEAR:             n_count = '0;
            default:              n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status     <= i_cmd.status;
            r_read_value <= (i_cmd.op == OP_READ) ? r_entries[i_position[IDX_W-1:0]] : '0;
        end
    end

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    assign o_item.read_value = r_read_value;
    assign o_item.length     = 5'(r_count);
    assign o_item.status     = r_status;

    dp_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    dp_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.op == OP_CLEAR) |=> (r_count == '0))
        else $error("clear left entries");

    dp_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.op == OP_INSERT) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow list");

    dp_error_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_cmd.status != ST_OK) |=> $stable(r_count))
        else $error("failed command changed length");

endmodule
